### hdl/lsc_pkg.sv
// Shared types and constants for the line sensor scan and centroid unit.
// No dependencies; imported by every module of the block.
package lsc_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = 3;
  localparam int SETTLE_W  = 10;
  localparam int MASK_W    = CHANNELS;
  localparam int ERR_W     = 4;
  localparam int POS_W     = 10;
  localparam int CNT_W     = 4;
  localparam int ESUM_W    = 5;
  localparam int DIV_W     = 12;
  localparam int DIV_STEPS = DIV_W;
  localparam int STEP_W    = 4;
  localparam int REM_W     = CNT_W;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 10'd10;
  localparam logic [POS_W-1:0]    NO_LINE_POS  = 10'd500;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 8'hFF;

  // steering and position weights per channel
  localparam int STEER_WEIGHT [CHANNELS] = '{-4, -3, -2, -1, 1, 2, 3, 4};
  localparam int POS_WEIGHT   [CHANNELS] = '{0, 143, 286, 429, 571, 714, 857, 1000};

  // register index of the configuration port
  localparam logic REG_SETTLE = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic step;      // accept one tick: advance scan state
    logic div_load;  // form sums from held mask, start divider
    logic div_run;   // one divider iteration
    logic out_tick;  // load output beat for a plain tick
    logic out_scan;  // load output beat for a scan-end tick
  } lsc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_end;  // this tick samples the last channel
    logic div_done;  // divider is on its last iteration
  } lsc_sts_t;

endpackage

### hdl/lsc_ctrl.sv
// Controller of the line sensor scan unit: tick acceptance, divider sequencing
// and the output beat valid flag. Depends on lsc_pkg.
module lsc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  lsc_pkg::lsc_sts_t sts,
  output lsc_pkg::lsc_cmd_t cmd
);
  import lsc_pkg::*;

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       accept;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_RUN) && slot_free;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // sequence commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_RUN: begin
        if (accept) begin
          cmd.step = 1'b1;
          if (sts.scan_end) begin
            state_nxt = S_LOAD;
          end else begin
            cmd.out_tick = 1'b1;
          end
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_scan = 1'b1;
          state_nxt    = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  // hold the output beat until taken
  always_comb begin
    if (cmd.out_tick || cmd.out_scan) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/lsc_datapath.sv
// Datapath of the line sensor scan unit: channel/settle counters, scan and
// held masks, weight sums, shift-subtract divider and output beat registers.
// Depends on lsc_pkg.
module lsc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsc_pkg::lsc_cmd_t             cmd,
  output lsc_pkg::lsc_sts_t             sts,
  input  logic [lsc_pkg::SETTLE_W-1:0]  settle_ticks,
  input  logic                          sensor_level,
  output logic [lsc_pkg::CH_W-1:0]      channel_select,
  output logic                          scan_done,
  output logic [lsc_pkg::MASK_W-1:0]    line_mask,
  output logic                          line_seen,
  output logic signed [lsc_pkg::ERR_W-1:0] steer_error,
  output logic [lsc_pkg::POS_W-1:0]     line_position
);
  import lsc_pkg::*;

  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic [MASK_W-1:0]   scan_r, scan_nxt;
  logic [MASK_W-1:0]   held_r, held_nxt;
  logic [MASK_W-1:0]   scan_new;
  logic                sample;

  logic signed [ERR_W-1:0] err_r;
  logic [POS_W-1:0]        pos_r;

  logic [CNT_W-1:0]        cnt;
  logic signed [ESUM_W-1:0] esum;
  logic [ESUM_W-1:0]       emag;
  logic [DIV_W-1:0]        psum;

  logic [DIV_W-1:0]  qe_r, qp_r, qe_nxt, qp_nxt;
  logic [REM_W-1:0]  re_r, rp_r, re_nxt, rp_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r, zero_r;
  logic [STEP_W-1:0] step_r;
  logic [REM_W:0]    trial_e, trial_p;
  logic              ge_e, ge_p;

  logic signed [ERR_W-1:0] err_fin;
  logic [POS_W-1:0]        pos_fin;

  // sample decision and scan update
  always_comb begin
    sample           = (settle_r >= settle_ticks);
    scan_new         = scan_r;
    scan_new[ch_r]   = sensor_level;
    sts.scan_end     = sample && (ch_r == CH_W'(CHANNELS - 1));
    sts.div_done     = (step_r == STEP_W'(DIV_STEPS - 1));
    ch_nxt           = ch_r;
    settle_nxt       = settle_r;
    scan_nxt         = scan_r;
    held_nxt         = held_r;
    if (cmd.step) begin
      if (sample) begin
        scan_nxt   = scan_new;
        settle_nxt = '0;
        if (sts.scan_end) begin
          held_nxt = scan_new;
          ch_nxt   = '0;
        end else begin
          ch_nxt = ch_r + CH_W'(1);
        end
      end else begin
        settle_nxt = settle_r + SETTLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r     <= '0;
      settle_r <= '0;
      scan_r   <= MASK_RESET;
      held_r   <= MASK_RESET;
    end else begin
      ch_r     <= ch_nxt;
      settle_r <= settle_nxt;
      scan_r   <= scan_nxt;
      held_r   <= held_nxt;
    end
  end

  // sum weights of dark sensors in the held mask
  always_comb begin
    cnt  = '0;
    esum = '0;
    psum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!held_r[i]) begin
        cnt  = cnt + CNT_W'(1);
        esum = esum + ESUM_W'(STEER_WEIGHT[i]);
        psum = psum + DIV_W'(POS_WEIGHT[i]);
      end
    end
    emag = esum[ESUM_W-1] ? ESUM_W'(-esum) : ESUM_W'(esum);
  end

  // one restoring division step on both lanes
  always_comb begin
    trial_e = {re_r, qe_r[DIV_W-1]};
    trial_p = {rp_r, qp_r[DIV_W-1]};
    ge_e    = (trial_e >= {1'b0, dvs_r});
    ge_p    = (trial_p >= {1'b0, dvs_r});
    re_nxt  = ge_e ? REM_W'(trial_e - {1'b0, dvs_r}) : trial_e[REM_W-1:0];
    rp_nxt  = ge_p ? REM_W'(trial_p - {1'b0, dvs_r}) : trial_p[REM_W-1:0];
    qe_nxt  = {qe_r[DIV_W-2:0], ge_e};
    qp_nxt  = {qp_r[DIV_W-2:0], ge_p};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      qe_r   <= DIV_W'(emag);
      qp_r   <= psum;
      re_r   <= '0;
      rp_r   <= '0;
      dvs_r  <= cnt;
      neg_r  <= esum[ESUM_W-1];
      zero_r <= (cnt == '0);
      step_r <= '0;
    end else if (cmd.div_run) begin
      qe_r   <= qe_nxt;
      qp_r   <= qp_nxt;
      re_r   <= re_nxt;
      rp_r   <= rp_nxt;
      step_r <= step_r + STEP_W'(1);
    end
  end

  // apply sign and the no-line defaults to the quotients
  always_comb begin
    if (zero_r) begin
      err_fin = '0;
      pos_fin = NO_LINE_POS;
    end else begin
      err_fin = neg_r ? -$signed(qe_r[ERR_W-1:0]) : $signed(qe_r[ERR_W-1:0]);
      pos_fin = qp_r[POS_W-1:0];
    end
  end

  // cache centroid of the held mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
      pos_r <= NO_LINE_POS;
    end else if (cmd.out_scan) begin
      err_r <= err_fin;
      pos_r <= pos_fin;
    end
  end

  // load the output beat
  always_ff @(posedge clk) begin
    if (cmd.out_tick) begin
      channel_select <= ch_r;
      scan_done      <= 1'b0;
      line_mask      <= held_r;
      line_seen      <= ~&held_r;
      steer_error    <= err_r;
      line_position  <= pos_r;
    end else if (cmd.out_scan) begin
      channel_select <= CH_W'(CHANNELS - 1);
      scan_done      <= 1'b1;
      line_mask      <= held_r;
      line_seen      <= ~&held_r;
      steer_error    <= err_fin;
      line_position  <= pos_fin;
    end
  end

endmodule

### hdl/line_sensor_scan_centroid_unit.sv
// A tick that samples no last channel gives its beat in the cycle after acceptance,
//   and such ticks go at one per cycle through the output register while beats are taken.
// A tick that completes a scan passes a sum step, the one-bit-per-cycle shift-subtract
//   divider and an output load that waits for the output slot, then acceptance resumes.
// Reset (synchronous, active low): settle_ticks 10, channel 0, masks all white,
//   error 0, position 500, no beat pending.
// Top level: APB settle register, controller and datapath. Depends on lsc_pkg,
// lsc_ctrl and lsc_datapath.
module line_sensor_scan_centroid_unit (
  input  logic        clk,
  input  logic        rst_n,
  // slave stream: tdata[0] sensor_level, tdata[7:1] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // master stream: tdata[2:0] channel_select, [10:3] line_mask, [11] line_seen,
  // [15:12] steer_error, [25:16] line_position, [31:26] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast,   // scan_done
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lsc_pkg::*;

  logic [SETTLE_W-1:0]     settle_r;
  lsc_cmd_t                cmd;
  lsc_sts_t                sts;
  logic [CH_W-1:0]         channel_select;
  logic [MASK_W-1:0]       line_mask;
  logic                    line_seen;
  logic signed [ERR_W-1:0] steer_error;
  logic [POS_W-1:0]        line_position;
  logic                    cfg_wr;

  // write the settle register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_SETTLE)) begin
      settle_r <= cfg_pwdata[SETTLE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SETTLE) ? 32'(settle_r) : '0;

  lsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lsc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .settle_ticks   (settle_r),
    .sensor_level   (in_tdata[0]),
    .channel_select (channel_select),
    .scan_done      (out_tlast),
    .line_mask      (line_mask),
    .line_seen      (line_seen),
    .steer_error    (steer_error),
    .line_position  (line_position)
  );

  // pack the result beat
  assign out_tdata = {6'b0, line_position, steer_error, line_seen, line_mask, channel_select};

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for line_sensor_scan_centroid_unit: drives sensor ticks and
// settle-register writes, and predicts each output beat with its own scan/centroid model.
// Depends on lsc_pkg and the line_sensor_scan_centroid_unit RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lsc_pkg::*;

  localparam logic [2:0]      ADDR_SETTLE    = 3'd0;
  localparam logic [2:0]      ADDR_SPARE     = 3'd4;  // no register behind this index
  localparam logic [CH_W-1:0] LAST_CHANNEL   = 3'd7;
  localparam int              WATCHDOG_LIMIT = 4000;
  localparam int              HOLD_CYCLES    = 400;
  localparam int              DRAIN_CYCLES   = 20;
  localparam int              MAX_REPORTS    = 40;
  localparam int              RANDOM_CHUNK   = 56;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic                     done;
    logic [MASK_W-1:0]        mask;
    logic                     seen;
    logic signed [ERR_W-1:0]  err;
    logic [POS_W-1:0]         pos;
  } scan_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [0] sensor_level, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [2:0] channel, [10:3] mask, [11] seen, [15:12] error, [25:16] pos
  logic        out_tlast;    // scan_done
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // scan model state
  logic [SETTLE_W-1:0] settle_lim;
  logic [CH_W-1:0]     chan;
  logic [SETTLE_W-1:0] wait_cnt;
  logic [MASK_W-1:0]   scan_acc;
  logic [MASK_W-1:0]   held;
  logic [MASK_W-1:0]   line_target;

  scan_beat_t expected_beats[$];
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_ack;
  int hold_left;
  int quiet_cycles;

  line_sensor_scan_centroid_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the scan by one tick and form the beat it produces.
  function automatic scan_beat_t centroid_step(input logic lvl);
    scan_beat_t b;
    int esum;
    int psum;
    int ndark;
    b.ch   = chan;
    b.done = 1'b0;
    if (wait_cnt >= settle_lim) begin
      scan_acc[chan] = lvl;
      wait_cnt       = '0;
      if (chan == LAST_CHANNEL) begin
        held   = scan_acc;
        b.done = 1'b1;
        chan   = '0;
      end else begin
        chan = chan + 1'b1;
      end
    end else begin
      wait_cnt = wait_cnt + 1'b1;
    end
    esum  = 0;
    psum  = 0;
    ndark = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!held[i]) begin
        // steering weight skips zero; position weight is 1000*i/7 rounded to nearest
        esum += (i < 4) ? i - 4 : i - 3;
        psum += (2000 * i + 7) / 14;
        ndark++;
      end
    end
    b.mask = held;
    b.seen = (ndark != 0);
    b.err  = ERR_W'((ndark != 0) ? esum / ndark : 0);
    b.pos  = POS_W'((ndark != 0) ? psum / ndark : 500);
    return b;
  endfunction

  // Pick the line pattern for the next scan: a short dark run, a random mask, or an extreme.
  function automatic logic [MASK_W-1:0] pick_line_mask();
    int sel;
    int w;
    int s;
    logic [15:0] run;
    sel = $urandom_range(9);
    if (sel == 0) return 8'hFF;
    if (sel == 1) return 8'h00;
    if (sel <= 5) begin
      w   = $urandom_range(1, 3);
      s   = $urandom_range(0, 7);
      run = ((16'd1 << w) - 16'd1) << s;
      return ~run[7:0];
    end
    return MASK_W'($urandom_range(255));
  endfunction

  // Follow the line pattern on sample ticks; add noise while settling, and a few glitches.
  function automatic logic next_level();
    if ($urandom_range(99) < 8) return 1'($urandom_range(1));
    if (wait_cnt >= settle_lim) return line_target[chan];
    return ($urandom_range(3) == 0) ? ~line_target[chan] : line_target[chan];
  endfunction

  task automatic report_field(input string name, input int want_v, input int got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
  endtask

  // Offer one tick, wait until it is accepted, then log the expected result.
  task automatic send_tick(input logic lvl);
    scan_beat_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, lvl};
    do @(posedge clk); while (!in_tready);
    b = centroid_step(lvl);
    expected_beats.push_back(b);
    if (b.done) line_target = pick_line_mask();
  endtask

  task automatic send_random_ticks(input int n);
    repeat (n) send_tick(next_level());
  endtask

  // Drop valid and hold until every expected beat has come back.
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_SETTLE) settle_lim = data[SETTLE_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) report_field("settle_ticks readback", want, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left = HOLD_CYCLES;
      hold_ack  = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each taken beat with the oldest expectation.
  always @(posedge clk) begin : check_beats
    scan_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: unexpected beat, expected none actual 0x%08h", $time, out_tdata);
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata[2:0] !== want.ch)     report_field("channel_select", want.ch, out_tdata[2:0]);
        if (out_tlast !== want.done)        report_field("scan_done", want.done, out_tlast);
        if (out_tdata[10:3] !== want.mask)  report_field("line_mask", want.mask, out_tdata[10:3]);
        if (out_tdata[11] !== want.seen)    report_field("line_seen", want.seen, out_tdata[11]);
        if (out_tdata[15:12] !== want.err)
          report_field("steer_error", want.err, $signed(out_tdata[15:12]));
        if (out_tdata[25:16] !== want.pos)
          report_field("line_position", want.pos, out_tdata[25:16]);
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Default settle: ten wait ticks, then channel 0 samples on the eleventh.
  task automatic test_reset_defaults();
    repeat (10) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Zero settle: every tick samples; all-dark scan, then rightmost sensor alone.
  task automatic test_directed_scans();
    wait_drain();
    apb_write(ADDR_SETTLE, 32'd0);
    repeat (7) send_tick(1'b0);
    repeat (7) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Readback, write to an unused index, and upper data bits dropped.
  task automatic test_register_access();
    wait_drain();
    apb_read_check(ADDR_SETTLE, 32'd0);
    apb_write(ADDR_SPARE, 32'h0000_03FF);
    apb_read_check(ADDR_SETTLE, 32'd0);
    apb_write(ADDR_SETTLE, 32'hFFFF_FC07);
    apb_read_check(ADDR_SETTLE, 32'd7);
    send_random_ticks(30);
  endtask

  // Hold the receiver off while ticks keep coming, so the block backs up.
  task automatic test_backpressure();
    wait_drain();
    apb_write(ADDR_SETTLE, 32'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    send_random_ticks(150);
  endtask

  // Random line patterns under three idling mixes and a range of short settle times.
  task automatic test_random_phases();
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 21 : (p == 1) ? 58 : 0;
      recv_idle_pct = (p == 0) ? 58 : (p == 1) ? 21 : 0;
      repeat (5) begin
        wait_drain();
        if ($urandom_range(3) == 0) apb_write(ADDR_SETTLE, $urandom_range(4, 12));
        else                        apb_write(ADDR_SETTLE, $urandom_range(0, 3));
        send_random_ticks(RANDOM_CHUNK);
      end
    end
  endtask

  // Largest settle time, then a shorter one written while a channel is mid-wait.
  task automatic test_settle_extremes();
    wait_drain();
    apb_write(ADDR_SETTLE, 32'hFFFF_FFFF);
    apb_read_check(ADDR_SETTLE, 32'd1023);
    send_random_ticks(40);
    wait_drain();
    apb_write(ADDR_SETTLE, 32'd2);
    send_random_ticks(20);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    hold_ack      = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    settle_lim    = 10'd10;
    chan          = '0;
    wait_cnt      = '0;
    scan_acc      = 8'hFF;
    held          = 8'hFF;
    line_target   = pick_line_mask();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_scans();
    test_register_access();
    test_backpressure();
    test_random_phases();
    test_settle_extremes();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/lsc_pkg.sv
hdl/lsc_ctrl.sv
hdl/lsc_datapath.sv
hdl/line_sensor_scan_centroid_unit.sv
tb/sv/tb_top.sv
